// ===== sv/i2cs_pkg.sv =====
// shared types, codes and helpers for the i2c transfer sequencer
// no dependencies; imported by the interfaces and every module
package i2cs_pkg;

  // longest transfer in either direction, in bytes
  localparam int MAX_TRANSFER = 255;

  // item kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // actions toward the bus engine
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ADDR     = 3'd1;
  localparam logic [2:0] ACT_DATA     = 3'd2;
  localparam logic [2:0] ACT_STOP     = 3'd3;
  localparam logic [2:0] ACT_NAK_STOP = 3'd4;
  localparam logic [2:0] ACT_ACK_READ = 3'd5;

  // transfer outcome
  localparam logic [1:0] OC_NONE = 2'd0;
  localparam logic [1:0] OC_OK   = 2'd1;
  localparam logic [1:0] OC_FAIL = 2'd2;

  // event flag patterns as reported by the engine
  localparam logic [2:0] FLAG_MB = 3'b001;
  localparam logic [2:0] FLAG_SB = 3'b010;

  // interrupt enable masks
  localparam logic [1:0] MASK_NONE = 2'b00;
  localparam logic [1:0] MASK_MB   = 2'b01;
  localparam logic [1:0] MASK_BOTH = 2'b11;

  // shifted addresses at or above this use the ten-bit form
  localparam logic [10:0] TEN_BIT_BASE = 11'h100;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] target_address;
    logic [7:0] first_byte;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [2:0] event_flags;
    logic [2:0] bus_status;
    logic [7:0] received_byte;
    logic [7:0] next_tx_byte;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] address_word;
    logic        ten_bit_mode;
    logic [7:0]  tx_data;
    logic [7:0]  rx_data;
    logic [8:0]  buffer_index;
    logic [1:0]  enable_mask;
    logic [1:0]  outcome;
    logic [15:0] bus_error_count;
    logic [15:0] nak_count;
    logic [15:0] other_error_count;
  } rsp_item_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] clamp_count(input logic [7:0] c);
    clamp_count = (int'(c) > MAX_TRANSFER) ? 8'(MAX_TRANSFER) : c;
  endfunction

  // ten-bit read header: 11110 a9 a8 1
  function automatic logic [10:0] read_header(input logic [10:0] sa);
    read_header = {3'b000, 4'hF, 1'b0, sa[10:9], 1'b1};
  endfunction

endpackage

// ===== sv/i2cs_if.sv =====
// valid/ready channel interfaces for requests and results
// depends on i2cs_pkg
interface i2cs_req_if import i2cs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] target_address;
  logic [7:0] first_byte;
  logic [7:0] write_count;
  logic [7:0] read_count;
  logic [2:0] event_flags;
  logic [2:0] bus_status;
  logic [7:0] received_byte;
  logic [7:0] next_tx_byte;

  modport source (
    output valid, kind, target_address, first_byte, write_count, read_count,
           event_flags, bus_status, received_byte, next_tx_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, target_address, first_byte, write_count, read_count,
           event_flags, bus_status, received_byte, next_tx_byte,
    output ready
  );
endinterface

interface i2cs_rsp_if import i2cs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [10:0] address_word;
  logic        ten_bit_mode;
  logic [7:0]  tx_data;
  logic [7:0]  rx_data;
  logic [8:0]  buffer_index;
  logic [1:0]  enable_mask;
  logic [1:0]  outcome;
  logic [15:0] bus_error_count;
  logic [15:0] nak_count;
  logic [15:0] other_error_count;

  modport source (
    output valid, action, address_word, ten_bit_mode, tx_data, rx_data, buffer_index,
           enable_mask, outcome, bus_error_count, nak_count, other_error_count,
    input  ready
  );
  modport sink (
    input  valid, action, address_word, ten_bit_mode, tx_data, rx_data, buffer_index,
           enable_mask, outcome, bus_error_count, nak_count, other_error_count,
    output ready
  );
endinterface

// ===== sv/i2c_master_transfer_sequencer.sv =====
// an accepted item is held until the result register has room; its result is then registered there
// throughput: one item per cycle while results are taken; the state machine steps once per item
// the result register frees as it is taken, so a stalled result blocks input only once both stages fill
// reset: synchronous rst returns to idle and zeroes all three error counters at once
// depends on i2cs_pkg, i2cs_if, i2cs_in_stage, i2cs_seq, i2cs_out_stage
module i2c_master_transfer_sequencer import i2cs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  i2cs_req_if.sink   req,
  i2cs_rsp_if.source rsp
);

  // item held in the input register
  logic      in_valid;
  req_item_t in_item;

  // step result, computed from the held item and the current state
  rsp_item_t step_res;

  // result register has room this cycle
  logic out_free;

  // one item steps the sequencer when it is held and the result has somewhere to go
  logic step;
  assign step = in_valid && out_free;

  // input register: next item may enter as the held one steps
  i2cs_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .take  (step),
    .valid (in_valid),
    .item  (in_item)
  );

  // transfer state machine and counters
  i2cs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (step_res)
  );

  // result register toward the consumer
  i2cs_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (step),
    .res  (step_res),
    .free (out_free),
    .rsp  (rsp)
  );

endmodule

// ===== sv/i2cs_in_stage.sv =====
// input register: captures one request item and holds it until stepped
// depends on i2cs_pkg and i2cs_req_if
module i2cs_in_stage import i2cs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  i2cs_req_if.sink   req,
  input  logic       take,
  output logic       valid,
  output req_item_t  item
);

  assign req.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item <= '{kind: req.kind, target_address: req.target_address,
                first_byte: req.first_byte, write_count: req.write_count,
                read_count: req.read_count, event_flags: req.event_flags,
                bus_status: req.bus_status, received_byte: req.received_byte,
                next_tx_byte: req.next_tx_byte};
    end
  end

endmodule

// ===== sv/i2cs_seq.sv =====
// transfer state machine and error counters; one step per item
// depends on i2cs_pkg
module i2cs_seq import i2cs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  req_item_t item,
  output rsp_item_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ADDR_WRITE, PH_WRITING, PH_TEN_READ, PH_ADDR_READ, PH_READING
  } phase_t;

  phase_t      phase, phase_next;
  logic [10:0] shifted_address, shifted_address_next;
  logic [7:0]  held_first_byte, held_first_byte_next;
  logic [7:0]  writes_left, writes_left_next;
  logic [7:0]  reads_left, reads_left_next;
  logic [8:0]  buffer_position, buffer_position_next;
  logic [15:0] bus_errors, bus_errors_next;
  logic [15:0] nak_errors, nak_errors_next;
  logic [15:0] other_errors, other_errors_next;
  logic        err;
  logic [7:0]  wc, rc, rl_dec;
  logic [10:0] sa_new;

  assign wc     = clamp_count(item.write_count);
  assign rc     = clamp_count(item.read_count);
  assign sa_new = {item.target_address, 1'b0};
  assign rl_dec = reads_left - 8'd1;

  always_comb begin
    phase_next           = phase;
    shifted_address_next = shifted_address;
    held_first_byte_next = held_first_byte;
    writes_left_next     = writes_left;
    reads_left_next      = reads_left;
    buffer_position_next = buffer_position;
    bus_errors_next      = bus_errors;
    nak_errors_next      = nak_errors;
    other_errors_next    = other_errors;
    err                  = 1'b0;
    res                  = '0;
    res.action           = ACT_NONE;
    res.outcome          = OC_NONE;
    res.enable_mask      = MASK_NONE;
    res.buffer_index     = buffer_position;

    case (item.kind)
      KIND_START: begin
        shifted_address_next = sa_new;
        held_first_byte_next = item.first_byte;
        writes_left_next     = wc;
        reads_left_next      = rc;
        buffer_position_next = '0;
        res.buffer_index     = '0;
        if (wc == 8'd0 && rc == 8'd0) begin
          phase_next  = PH_IDLE;
          res.outcome = OC_OK;
        end else if (wc != 8'd0) begin
          phase_next         = PH_ADDR_WRITE;
          res.action         = ACT_ADDR;
          res.address_word   = sa_new;
          res.ten_bit_mode   = (sa_new >= TEN_BIT_BASE);
          res.enable_mask    = MASK_MB;
        end else if (sa_new >= TEN_BIT_BASE) begin
          phase_next         = PH_TEN_READ;
          res.action         = ACT_ADDR;
          res.address_word   = sa_new;
          res.ten_bit_mode   = 1'b1;
          res.enable_mask    = MASK_MB;
        end else begin
          phase_next         = PH_ADDR_READ;
          res.action         = ACT_ADDR;
          res.address_word   = sa_new | 11'd1;
          res.enable_mask    = MASK_BOTH;
        end
      end

      KIND_EVENT: begin
        case (phase)
          PH_ADDR_WRITE: begin
            if (item.event_flags == FLAG_MB) begin
              res.action       = ACT_DATA;
              res.tx_data      = held_first_byte;
              writes_left_next = writes_left - 8'd1;
              res.enable_mask  = MASK_MB;
              phase_next       = PH_WRITING;
            end else begin
              err = 1'b1;
            end
          end
          PH_WRITING: begin
            if (item.event_flags != FLAG_MB) begin
              err = 1'b1;
            end else if (writes_left != 8'd0) begin
              res.action           = ACT_DATA;
              res.tx_data          = item.next_tx_byte;
              buffer_position_next = buffer_position + 9'd1;
              writes_left_next     = writes_left - 8'd1;
              res.enable_mask      = MASK_MB;
            end else if (reads_left == 8'd0) begin
              res.action  = ACT_STOP;
              res.outcome = OC_OK;
              phase_next  = PH_IDLE;
            end else begin
              res.action       = ACT_ADDR;
              res.address_word = (shifted_address >= TEN_BIT_BASE) ?
                                 read_header(shifted_address) :
                                 (shifted_address | 11'd1);
              res.enable_mask  = MASK_BOTH;
              phase_next       = PH_ADDR_READ;
            end
          end
          PH_TEN_READ: begin
            if (item.event_flags == FLAG_MB) begin
              res.action       = ACT_ADDR;
              res.address_word = read_header(shifted_address);
              res.enable_mask  = MASK_BOTH;
              phase_next       = PH_ADDR_READ;
            end else begin
              err = 1'b1;
            end
          end
          PH_ADDR_READ, PH_READING: begin
            phase_next = PH_READING;
            if (item.event_flags != FLAG_SB) begin
              err = 1'b1;
            end else begin
              reads_left_next      = rl_dec;
              res.rx_data          = item.received_byte;
              buffer_position_next = buffer_position + 9'd1;
              if (rl_dec == 8'd0) begin
                res.action  = ACT_NAK_STOP;
                res.outcome = OC_OK;
                phase_next  = PH_IDLE;
              end else begin
                res.action      = ACT_ACK_READ;
                res.enable_mask = MASK_BOTH;
              end
            end
          end
          default: begin
            // idle: event is ignored
          end
        endcase
        if (err) begin
          if (item.bus_status[1:0] != 2'b00) begin
            bus_errors_next = sat_inc16(bus_errors);
          end else if (item.bus_status[2]) begin
            nak_errors_next = sat_inc16(nak_errors);
          end else begin
            other_errors_next = sat_inc16(other_errors);
          end
          res.action      = ACT_STOP;
          res.outcome     = OC_FAIL;
          res.enable_mask = MASK_NONE;
          phase_next      = PH_IDLE;
        end
      end

      KIND_TIMEOUT: begin
        if (phase != PH_IDLE) begin
          res.outcome = OC_FAIL;
          phase_next  = PH_IDLE;
        end
      end

      default: begin
        bus_errors_next   = '0;
        nak_errors_next   = '0;
        other_errors_next = '0;
        if (phase == PH_ADDR_WRITE || phase == PH_WRITING || phase == PH_TEN_READ) begin
          res.enable_mask = MASK_MB;
        end else if (phase == PH_ADDR_READ || phase == PH_READING) begin
          res.enable_mask = MASK_BOTH;
        end
      end
    endcase

    res.bus_error_count   = bus_errors_next;
    res.nak_count         = nak_errors_next;
    res.other_error_count = other_errors_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      shifted_address <= '0;
      held_first_byte <= '0;
      writes_left     <= '0;
      reads_left      <= '0;
      buffer_position <= '0;
      bus_errors      <= '0;
      nak_errors      <= '0;
      other_errors    <= '0;
    end else if (step) begin
      phase           <= phase_next;
      shifted_address <= shifted_address_next;
      held_first_byte <= held_first_byte_next;
      writes_left     <= writes_left_next;
      reads_left      <= reads_left_next;
      buffer_position <= buffer_position_next;
      bus_errors      <= bus_errors_next;
      nak_errors      <= nak_errors_next;
      other_errors    <= other_errors_next;
    end
  end

`ifndef SYNTH
  // a finished transfer always leaves the sequencer idle
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.outcome != OC_NONE |=> phase == PH_IDLE)
    else $error("sequencer not idle after transfer outcome");

  // counters only move down on a clear item
  a_counter_monotonic: assert property (@(posedge clk) disable iff (rst)
    step && item.kind != KIND_CLEAR |=>
      bus_errors >= $past(bus_errors) && nak_errors >= $past(nak_errors) &&
      other_errors >= $past(other_errors))
    else $error("error counter decreased without clear");

  // a failed transfer awaits no further events
  a_fail_no_mask: assert property (@(posedge clk) disable iff (rst)
    step && res.outcome == OC_FAIL |-> res.enable_mask == MASK_NONE)
    else $error("enable mask set on failed transfer");

  // idle state never asks for events
  a_idle_no_mask: assert property (@(posedge clk) disable iff (rst)
    step && phase_next == PH_IDLE |-> res.enable_mask == MASK_NONE)
    else $error("enable mask set while going idle");
`endif

endmodule

// ===== sv/i2cs_out_stage.sv =====
// result register driving the result channel
// depends on i2cs_pkg and i2cs_rsp_if
module i2cs_out_stage import i2cs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rsp_item_t  res,
  output logic       free,
  i2cs_rsp_if.source rsp
);

  rsp_item_t held;

  assign free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (free) begin
      rsp.valid <= load;
    end
    if (load) begin
      held <= res;
    end
  end

  assign rsp.action            = held.action;
  assign rsp.address_word      = held.address_word;
  assign rsp.ten_bit_mode      = held.ten_bit_mode;
  assign rsp.tx_data           = held.tx_data;
  assign rsp.rx_data           = held.rx_data;
  assign rsp.buffer_index      = held.buffer_index;
  assign rsp.enable_mask       = held.enable_mask;
  assign rsp.outcome           = held.outcome;
  assign rsp.bus_error_count   = held.bus_error_count;
  assign rsp.nak_count         = held.nak_count;
  assign rsp.other_error_count = held.other_error_count;

endmodule
